[rtl/qrpy_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpy_pkg
// shared constants, types and the arctangent table of the roll-pitch-yaw core
// ----------------------------------------------------------------------------
package qrpy_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int ARG_W        = 33;
    localparam int CW           = 60;
    localparam int ANG_W        = 34;
    localparam int SUM_W        = 35;
    localparam int THR_W        = 11;

    localparam logic [THR_W-1:0] THR_RESET = 11'd1;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [SUM_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [SUM_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [SUM_W-1:0] PI_Q29      = 35'sd1686629713;
    localparam logic signed [SUM_W-1:0] HALF_PI_Q29 = 35'sd843314857;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [30:0] pitch;
        logic signed [31:0] yaw;
    } out_word_t;

    // arctangent of 2^-i in radians * 2^30, truncated toward zero
    function automatic logic [30:0] atan_entry(input int i);
        logic [30:0] r;
        case (i)
            0:       r = 31'd843314856;
            1:       r = 31'd497837829;
            2:       r = 31'd263043836;
            3:       r = 31'd133525158;
            4:       r = 31'd67021686;
            5:       r = 31'd33543515;
            6:       r = 31'd16775850;
            7:       r = 31'd8388437;
            8:       r = 31'd4194282;
            9:       r = 31'd2097149;
            default:
            begin
                if (i < 30)
                    r = 31'((64'd1 << (30 - i)) - 64'd1);
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/qrpy_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpy_isqrt
// pipelined digit-by-digit floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module qrpy_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root
);

    logic [63:0] n_reg   [0:qrpy_pkg::SQRT_STEPS-1];
    logic [63:0] res_reg [0:qrpy_pkg::SQRT_STEPS-1];

    genvar k;
    generate
        for (k = 0; k < qrpy_pkg::SQRT_STEPS; k++)
        begin : g_step
            localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
            logic [63:0] n_src;
            logic [63:0] res_src;
            logic [63:0] trial;
            logic [63:0] n_next;
            logic [63:0] res_next;

            if (k == 0)
            begin : g_first
                assign n_src   = radicand;
                assign res_src = '0;
            end
            else
            begin : g_rest
                assign n_src   = n_reg[k-1];
                assign res_src = res_reg[k-1];
            end

            always_comb
            begin
                trial = res_src + BITV;
                if (n_src >= trial)
                begin
                    n_next   = n_src - trial;
                    res_next = (res_src >> 1) + BITV;
                end
                else
                begin
                    n_next   = n_src;
                    res_next = res_src >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k]   <= n_next;
                    res_reg[k] <= res_next;
                end
            end
        end
    endgenerate

    assign root = res_reg[qrpy_pkg::SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

[rtl/qrpy_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrpy_cordic
// pipelined vectoring cordic atan2, quadrant fold then one rotation per stage
// ----------------------------------------------------------------------------
module qrpy_cordic (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [qrpy_pkg::ARG_W-1:0]     y_in,
    input  wire logic signed [qrpy_pkg::ARG_W-1:0]     x_in,
    input  wire logic                                  force_zero,
    output logic signed      [qrpy_pkg::ANG_W-1:0]     angle
);

    localparam int N = qrpy_pkg::CORDIC_STEPS;

    logic signed [qrpy_pkg::CW-1:0]    x_reg [0:N];
    logic signed [qrpy_pkg::CW-1:0]    y_reg [0:N];
    logic signed [qrpy_pkg::ANG_W-1:0] a_reg [0:N];
    logic                              z_reg [0:N];

    logic signed [qrpy_pkg::CW-1:0]    xp;
    logic signed [qrpy_pkg::CW-1:0]    yp;
    logic signed [qrpy_pkg::CW-1:0]    x0_next;
    logic signed [qrpy_pkg::CW-1:0]    y0_next;
    logic signed [qrpy_pkg::ANG_W-1:0] a0_next;
    logic                              z0_next;

    // prescale by 2^24 and fold the left half plane
    always_comb
    begin
        xp      = {{(qrpy_pkg::CW-qrpy_pkg::ARG_W-24){x_in[qrpy_pkg::ARG_W-1]}}, x_in, 24'd0};
        yp      = {{(qrpy_pkg::CW-qrpy_pkg::ARG_W-24){y_in[qrpy_pkg::ARG_W-1]}}, y_in, 24'd0};
        z0_next = force_zero || ((x_in == '0) && (y_in == '0));
        x0_next = xp;
        y0_next = yp;
        a0_next = '0;
        if (xp < 0)
        begin
            if (yp >= 0)
            begin
                x0_next = yp;
                y0_next = -xp;
                a0_next = qrpy_pkg::HALF_PI_Q30;
            end
            else
            begin
                x0_next = -yp;
                y0_next = xp;
                a0_next = -qrpy_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            a_reg[0] <= a0_next;
            z_reg[0] <= z0_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_rot
            localparam logic signed [qrpy_pkg::ANG_W-1:0] ATAN =
                qrpy_pkg::ANG_W'({3'b000, qrpy_pkg::atan_entry(i)});
            logic signed [qrpy_pkg::CW-1:0] dx;
            logic signed [qrpy_pkg::CW-1:0] dy;

            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[i+1] <= z_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        a_reg[i+1] <= a_reg[i] + ATAN;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        a_reg[i+1] <= a_reg[i] - ATAN;
                    end
                end
            end
        end
    endgenerate

    assign angle = z_reg[N] ? '0 : a_reg[N];

endmodule
`default_nettype wire

[rtl/quaternion_to_roll_pitch_yaw_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_roll_pitch_yaw_core
// unit quaternion plus rotation matrix column to roll, pitch and yaw
// ----------------------------------------------------------------------------
// The core takes one word per cycle while in_ready is high and returns one
// word per input, in order. Most of the depth comes from the 32-stage square
// root that feeds the pitch cordic (one root bit per stage) followed by the
// 31-stage cordic (quadrant fold plus 30 rotations); the two half-angle
// cordics run alongside on delayed arguments. A two-word output buffer
// decouples the pipeline from out_ready, so inputs keep being taken while a
// result waits; the pipeline freezes only when both buffer slots are full.
// Angles are radians * 2^29. singular_threshold (reset 1) zeroes a half-angle
// when both of its atan2 arguments have magnitude at or below it.
// ----------------------------------------------------------------------------
module quaternion_to_roll_pitch_yaw_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [10:0]        cfg_wr_data,
    // input word
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] quat_w,
    input  wire logic signed [31:0] quat_x,
    input  wire logic signed [31:0] quat_y,
    input  wire logic signed [31:0] quat_z,
    input  wire logic signed [31:0] rot_00,
    input  wire logic signed [31:0] rot_10,
    input  wire logic signed [31:0] rot_20,
    input  wire logic signed [31:0] rot_21,
    input  wire logic signed [31:0] rot_22,
    // result word
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      roll_rad,
    output logic signed [30:0]      pitch_rad,
    output logic signed [31:0]      yaw_rad
);

    localparam int AW    = qrpy_pkg::ARG_W;
    localparam int DLY   = qrpy_pkg::SQRT_STEPS + 1;
    localparam int LAT   = 2 + qrpy_pkg::SQRT_STEPS + qrpy_pkg::CORDIC_STEPS + 1 + 3;

    typedef struct packed {
        logic signed [AW-1:0] ya;
        logic signed [AW-1:0] xa;
        logic signed [AW-1:0] yb;
        logic signed [AW-1:0] xb;
        logic signed [AW-1:0] ny;
        logic                 za_zero;
        logic                 zb_zero;
    } arg_t;

    // configuration register
    logic [qrpy_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= qrpy_pkg::THR_RESET;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    // pipeline advance and valid tracking
    logic           en;
    logic [1:LAT]   v_reg;
    logic [1:0]     cnt_reg;

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {in_valid, v_reg[1:LAT-1]};
    end

    // stage 1: squares, half-angle arguments, singular tests
    function automatic logic small_mag(input logic signed [AW-1:0] v,
                                       input logic [qrpy_pkg::THR_W-1:0] t);
        logic signed [AW:0] e;
        logic signed [AW:0] m;
        e = {v[AW-1], v};
        m = (e < 0) ? -e : e;
        return m <= $signed({{(AW+1-qrpy_pkg::THR_W){1'b0}}, t});
    endfunction

    logic [62:0]    sq_reg [0:3];
    arg_t           arg_reg;
    arg_t           arg_next;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;

    always_comb
    begin
        p0 = rot_22 * rot_22;
        p1 = rot_21 * rot_21;
        p2 = rot_10 * rot_10;
        p3 = rot_00 * rot_00;
        arg_next.ya = AW'(quat_x) + AW'(quat_z);
        arg_next.xa = AW'(quat_w) - AW'(quat_y);
        arg_next.yb = AW'(quat_z) - AW'(quat_x);
        arg_next.xb = AW'(quat_w) + AW'(quat_y);
        arg_next.ny = -AW'(rot_20);
        arg_next.za_zero = small_mag(arg_next.ya, thr_reg) && small_mag(arg_next.xa, thr_reg);
        arg_next.zb_zero = small_mag(arg_next.yb, thr_reg) && small_mag(arg_next.xb, thr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= p0[62:0];
            sq_reg[1] <= p1[62:0];
            sq_reg[2] <= p2[62:0];
            sq_reg[3] <= p3[62:0];
            arg_reg   <= arg_next;
        end
    end

    // stage 2: half of the sum of squares; arguments enter a delay line
    logic [63:0] half_reg;
    logic [64:0] sq_sum;
    arg_t        dly_reg [0:DLY-1];

    assign sq_sum = 65'(sq_reg[0]) + 65'(sq_reg[1]) + 65'(sq_reg[2]) + 65'(sq_reg[3]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_reg   <= sq_sum[64:1];
            dly_reg[0] <= arg_reg;
            for (int k = 1; k < DLY; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    // square root, aligned with the last delay tap
    logic [31:0] rsum;

    qrpy_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (half_reg),
        .root     (rsum)
    );

    // three atan2 pipelines in lockstep
    arg_t                              arg_d;
    logic signed [qrpy_pkg::ANG_W-1:0] pitch_q30;
    logic signed [qrpy_pkg::ANG_W-1:0] za_q30;
    logic signed [qrpy_pkg::ANG_W-1:0] zb_q30;

    assign arg_d = dly_reg[DLY-1];

    qrpy_cordic u_cordic_pitch (
        .clk        (clk),
        .en         (en),
        .y_in       (arg_d.ny),
        .x_in       ({1'b0, rsum}),
        .force_zero (1'b0),
        .angle      (pitch_q30)
    );

    qrpy_cordic u_cordic_za (
        .clk        (clk),
        .en         (en),
        .y_in       (arg_d.ya),
        .x_in       (arg_d.xa),
        .force_zero (arg_d.za_zero),
        .angle      (za_q30)
    );

    qrpy_cordic u_cordic_zb (
        .clk        (clk),
        .en         (en),
        .y_in       (arg_d.yb),
        .x_in       (arg_d.xb),
        .force_zero (arg_d.zb_zero),
        .angle      (zb_q30)
    );

    // combine half-angles, wrap once into [-pi, pi], round to 2^29 and clamp
    logic signed [qrpy_pkg::SUM_W-1:0] roll_sum_reg;
    logic signed [qrpy_pkg::SUM_W-1:0] yaw_sum_reg;
    logic signed [qrpy_pkg::SUM_W-1:0] pitch_sum_reg;
    logic signed [qrpy_pkg::SUM_W-1:0] roll_wrap_reg;
    logic signed [qrpy_pkg::SUM_W-1:0] yaw_wrap_reg;
    logic signed [qrpy_pkg::SUM_W-1:0] pitch_wrap_reg;
    qrpy_pkg::out_word_t               res_reg;
    qrpy_pkg::out_word_t               res_next;

    function automatic logic signed [qrpy_pkg::SUM_W-1:0] wrap_pi(
        input logic signed [qrpy_pkg::SUM_W-1:0] v);
        logic signed [qrpy_pkg::SUM_W-1:0] r;
        r = v;
        if (v > qrpy_pkg::PI_Q30)
            r = v - qrpy_pkg::TWO_PI_Q30;
        else if (v < -qrpy_pkg::PI_Q30)
            r = v + qrpy_pkg::TWO_PI_Q30;
        return r;
    endfunction

    function automatic logic signed [qrpy_pkg::SUM_W-1:0] round_sat(
        input logic signed [qrpy_pkg::SUM_W-1:0] v,
        input logic signed [qrpy_pkg::SUM_W-1:0] lim);
        logic signed [qrpy_pkg::SUM_W-1:0] r;
        r = (v + 35'sd1) >>> 1;
        if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r;
    endfunction

    always_comb
    begin
        res_next.roll  = 32'(round_sat(roll_wrap_reg, qrpy_pkg::PI_Q29));
        res_next.pitch = 31'(round_sat(pitch_wrap_reg, qrpy_pkg::HALF_PI_Q29));
        res_next.yaw   = 32'(round_sat(yaw_wrap_reg, qrpy_pkg::PI_Q29));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_sum_reg   <= 35'(za_q30) - 35'(zb_q30);
            yaw_sum_reg    <= 35'(za_q30) + 35'(zb_q30);
            pitch_sum_reg  <= 35'(pitch_q30);
            roll_wrap_reg  <= wrap_pi(roll_sum_reg);
            yaw_wrap_reg   <= wrap_pi(yaw_sum_reg);
            pitch_wrap_reg <= pitch_sum_reg;
            res_reg        <= res_next;
        end
    end

    // two-word output buffer
    qrpy_pkg::out_word_t buf_reg [0:1];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic                push;
    logic                pop;

    assign push = en && v_reg[LAT];
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign roll_rad  = buf_reg[rd_ptr_reg].roll;
    assign pitch_rad = buf_reg[rd_ptr_reg].pitch;
    assign yaw_rad   = buf_reg[rd_ptr_reg].yaw;

endmodule
`default_nettype wire

[bench/tb_quaternion_to_roll_pitch_yaw_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_roll_pitch_yaw_core
// self-checking bench for the quaternion to roll-pitch-yaw core
// ----------------------------------------------------------------------------
// Feeds unit quaternions with matching matrix elements, near-singular pairs,
// edge values and raw bit noise through the valid/ready ports under random
// idling and one long output stall. A bit-exact predictor computes the angles
// of every accepted word, and each returned word is compared in order. The
// singular threshold is stepped through several values, 0 and 1024 included.
// ----------------------------------------------------------------------------
module tb_quaternion_to_roll_pitch_yaw_core;

    typedef struct {
        logic signed [31:0] w, x, y, z;
        logic signed [31:0] r00, r10, r20, r21, r22;
    } quat_word_t;

    // bit-exact angle predictor plus the in-order store of expected words
    class rpy_scoreboard;
        longint              thr;
        qrpy_pkg::out_word_t pending[$];
        int                  mismatches;
        int                  checked;
        int                  accepted;

        function new();
            thr        = 1;
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
        endfunction

        // arctangent of 2^-i, radians * 2^30, truncated toward zero
        function longint arctan_step(int i);
            longint head[10] = '{843314856, 497837829, 263043836, 133525158,
                                 67021686, 33543515, 16775850, 8388437,
                                 4194282, 2097149};
            if (i < 10)
                return head[i];
            if (i < 30)
                return (longint'(1) << (30 - i)) - 1;
            return 0;
        endfunction

        // vectoring cordic, radians * 2^30
        function longint vector_angle(longint yy, longint xx);
            longint ang, t, dx, dy;
            ang = 0;
            if (xx == 0 && yy == 0)
                return 0;
            xx = xx * 64'sd16777216;
            yy = yy * 64'sd16777216;
            // fold the left half plane by a quarter turn
            if (xx < 0)
            begin
                t = xx;
                if (yy >= 0)
                begin
                    xx  = yy;
                    yy  = -t;
                    ang = 1686629713;
                end
                else
                begin
                    xx  = -yy;
                    yy  = t;
                    ang = -1686629713;
                end
            end
            for (int i = 0; i < 30; i++)
            begin
                dx = yy >>> i;
                dy = xx >>> i;
                if (yy >= 0)
                begin
                    xx  += dx;
                    yy  -= dy;
                    ang += arctan_step(i);
                end
                else
                begin
                    xx  -= dx;
                    yy  += dy;
                    ang -= arctan_step(i);
                end
            end
            return ang;
        endfunction

        // floor square root, digit by digit
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n  -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function longint absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint wrap_turn(longint v);
            if (v > 64'sd3373259426)
                v -= 64'sd6746518852;
            if (v < -64'sd3373259426)
                v += 64'sd6746518852;
            return v;
        endfunction

        // radians * 2^30 to * 2^29, ties up, then clamp
        function longint round_clamp(longint v, longint lim);
            longint r;
            r = (v + 1) >>> 1;
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            return r;
        endfunction

        function void note(quat_word_t q);
            longint unsigned     s0, s1, s2, s3, half;
            longint              w, x, y, z, a, b, c, d, rsum, za, zb, pt, rl, yw;
            qrpy_pkg::out_word_t e;
            w  = q.w;
            x  = q.x;
            y  = q.y;
            z  = q.z;
            a  = q.r22;
            b  = q.r21;
            c  = q.r10;
            d  = q.r00;
            s0 = a * a;
            s1 = b * b;
            s2 = c * c;
            s3 = d * d;
            half = (s0 >> 1) + (s1 >> 1) + (s2 >> 1) + (s3 >> 1)
                 + (((s0 & 1) + (s1 & 1) + (s2 & 1) + (s3 & 1)) >> 1);
            rsum = longint'(floor_root(half));
            pt   = vector_angle(-longint'(q.r20), rsum);
            za   = 0;
            zb   = 0;
            if (!(absval(x + z) <= thr && absval(w - y) <= thr))
                za = vector_angle(x + z, w - y);
            if (!(absval(z - x) <= thr && absval(w + y) <= thr))
                zb = vector_angle(z - x, w + y);
            rl = wrap_turn(za - zb);
            yw = wrap_turn(za + zb);
            e.roll  = 32'(round_clamp(rl, 1686629713));
            e.pitch = 31'(round_clamp(pt, 843314857));
            e.yaw   = 32'(round_clamp(yw, 1686629713));
            pending.push_back(e);
            accepted++;
        endfunction

        function void check(qrpy_pkg::out_word_t act);
            qrpy_pkg::out_word_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word roll=%0d pitch=%0d yaw=%0d",
                             act.roll, act.pitch, act.yaw);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (act.roll !== e.roll || act.pitch !== e.pitch || act.yaw !== e.yaw)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             checked, e.roll, e.pitch, e.yaw,
                             act.roll, act.pitch, act.yaw);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [10:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [31:0] rot_00, rot_10, rot_20, rot_21, rot_22;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] roll_rad;
    logic signed [30:0] pitch_rad;
    logic signed [31:0] yaw_rad;

    rpy_scoreboard sb = new();

    // no idling on either side while set
    bit calm;
    // output side held off for the long stall
    bit hold_off;
    int n_unit, n_sing, n_noise, n_edge;

    quaternion_to_roll_pitch_yaw_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .rot_00      (rot_00),
        .rot_10      (rot_10),
        .rot_20      (rot_20),
        .rot_21      (rot_21),
        .rot_22      (rot_22),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .roll_rad    (roll_rad),
        .pitch_rad   (pitch_rad),
        .yaw_rad     (yaw_rad)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // real number to Q1.30, clamped to the unit range
    function automatic logic signed [31:0] to_q130(real v);
        if (v > 1.0)
            v = 1.0;
        if (v < -1.0)
            v = -1.0;
        return 32'($rtoi(v * 1073741824.0));
    endfunction

    function automatic real rand_unit();
        return ($urandom / 4294967296.0) * 2.0 - 1.0;
    endfunction

    // matrix elements that belong to the quaternion (w,x,y,z)
    function automatic quat_word_t from_real(real w, real x, real y, real z);
        quat_word_t q;
        real        n;
        n = $sqrt(w * w + x * x + y * y + z * z);
        if (n < 1.0e-9)
        begin
            w = 1.0;
            n = 1.0;
        end
        w = w / n;
        x = x / n;
        y = y / n;
        z = z / n;
        q.w   = to_q130(w);
        q.x   = to_q130(x);
        q.y   = to_q130(y);
        q.z   = to_q130(z);
        q.r00 = to_q130(1.0 - 2.0 * (y * y + z * z));
        q.r10 = to_q130(2.0 * (x * y + w * z));
        q.r20 = to_q130(2.0 * (x * z - w * y));
        q.r21 = to_q130(2.0 * (y * z + w * x));
        q.r22 = to_q130(1.0 - 2.0 * (x * x + y * y));
        return q;
    endfunction

    function automatic logic signed [31:0] edge_value();
        case ($urandom_range(6))
            0:       return 32'sh4000_0000;
            1:       return -32'sh4000_0000;
            2:       return 32'sh7fff_ffff;
            3:       return 32'sh8000_0000;
            4:       return 32'sd0;
            5:       return 32'(int'($urandom_range(2048)) - 1024);
            default: return 32'($urandom);
        endcase
    endfunction

    // one random word from the weighted mix
    function automatic quat_word_t random_word();
        quat_word_t q;
        int         k;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            q = from_real(rand_unit(), rand_unit(), rand_unit(), rand_unit());
            n_unit++;
        end
        else if (pick < 78)
        begin
            // near gimbal lock: one of the half-angle pairs close to zero
            q = from_real(rand_unit(), rand_unit(), rand_unit(), rand_unit());
            k = $urandom_range(2);
            if (k != 1)
            begin
                q.y = q.w - 32'(int'($urandom_range(2200)) - 1100);
                q.z = -q.x + 32'(int'($urandom_range(2200)) - 1100);
            end
            if (k != 0)
            begin
                q.y = -q.w + 32'(int'($urandom_range(2200)) - 1100);
                q.z = q.x + 32'(int'($urandom_range(2200)) - 1100);
            end
            n_sing++;
        end
        else if (pick < 90)
        begin
            q.w   = 32'($urandom);
            q.x   = 32'($urandom);
            q.y   = 32'($urandom);
            q.z   = 32'($urandom);
            q.r00 = 32'($urandom);
            q.r10 = 32'($urandom);
            q.r20 = 32'($urandom);
            q.r21 = 32'($urandom);
            q.r22 = 32'($urandom);
            n_noise++;
        end
        else
        begin
            q.w   = edge_value();
            q.x   = edge_value();
            q.y   = edge_value();
            q.z   = edge_value();
            q.r00 = edge_value();
            q.r10 = edge_value();
            q.r20 = edge_value();
            q.r21 = edge_value();
            q.r22 = edge_value();
            n_edge++;
        end
        return q;
    endfunction

    function automatic quat_word_t fill(logic signed [31:0] v);
        quat_word_t q;
        q.w   = v;
        q.x   = v;
        q.y   = v;
        q.z   = v;
        q.r00 = v;
        q.r10 = v;
        q.r20 = v;
        q.r21 = v;
        q.r22 = v;
        return q;
    endfunction

    // called at a falling edge, returns at a falling edge after acceptance
    task automatic send_word(quat_word_t q);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 38)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_w   <= q.w;
        quat_x   <= q.x;
        quat_y   <= q.y;
        quat_z   <= q.z;
        rot_00   <= q.r00;
        rot_10   <= q.r10;
        rot_20   <= q.r20;
        rot_21   <= q.r21;
        rot_22   <= q.r22;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note(q);
        @(negedge clk);
    endtask

    // stop offering, let the pipeline drain, then write the threshold
    task automatic set_threshold(logic [10:0] v);
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        // latency of the core plus margin
        repeat (80) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.thr = v;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            // a stretch with no idling at all in the middle of each phase
            calm = (i >= count / 3) && (i < count / 3 + 60);
            send_word(random_word());
        end
        calm = 1'b0;
    endtask

    // receiver: random idling, long hold-off, compare at the rising edge
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check('{roll: roll_rad, pitch: pitch_rad, yaw: yaw_rad});
    end

    // long output stall while the sender keeps offering words
    initial
    begin
        hold_off = 1'b0;
        wait (sb.accepted >= 400);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    // hard limit on the run
    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        quat_word_t q;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        calm        = 1'b0;
        q           = fill(32'sd0);
        {quat_w, quat_x, quat_y, quat_z} = '0;
        {rot_00, rot_10, rot_20, rot_21, rot_22} = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words with the reset threshold
        send_word(fill(32'sd0));
        send_word(fill(32'sh7fff_ffff));
        send_word(fill(32'sh8000_0000));
        send_word(fill(32'sh4000_0000));
        send_word(fill(-32'sh4000_0000));
        send_word(from_real(1.0, 0.0, 0.0, 0.0));
        send_word(from_real(0.0, 1.0, 0.0, 0.0));
        send_word(from_real(0.0, 0.0, 1.0, 0.0));
        send_word(from_real(0.0, 0.0, 0.0, 1.0));
        // gimbal lock at pitch of plus and minus a quarter turn
        send_word(from_real(0.7071067811865476, 0.0, 0.7071067811865476, 0.0));
        send_word(from_real(0.7071067811865476, 0.0, -0.7071067811865476, 0.0));
        send_word(from_real(0.5, 0.5, 0.5, -0.5));
        // negative abscissa with ordinate of either sign
        send_word(from_real(-0.9, 0.3, 0.1, 0.2));
        send_word(from_real(-0.9, -0.3, 0.1, -0.2));
        send_word(from_real(0.1, 0.6, -0.7, 0.3));
        // pitch saturating: large ordinate with zero abscissa
        q = fill(32'sd0);
        q.r20 = 32'sh8000_0000;
        send_word(q);
        q.r20 = 32'sh7fff_ffff;
        send_word(q);
        // arguments just at and above the threshold
        q = fill(32'sd0);
        q.x = 32'sd1;
        q.w = -32'sd1;
        send_word(q);
        q.x = 32'sd2;
        send_word(q);
        // wrap of roll and yaw near a half turn
        send_word(from_real(0.001, 0.999, 0.0, 0.002));
        send_word(from_real(0.001, -0.999, 0.0, 0.002));

        run_random(250);
        set_threshold(11'd0);
        run_random(250);
        set_threshold(11'd1024);
        run_random(250);
        set_threshold(11'($urandom_range(1023)));
        run_random(200);
        set_threshold(11'd1);
        run_random(150);

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (sb.pending.size() != 0)
            sb.mismatches++;

        $display("covered %0d words: %0d unit, %0d near singular, %0d noise, %0d edge",
                 sb.accepted, n_unit, n_sing, n_noise, n_edge);
        $display("thresholds 1, 0, 1024, random and 1; %0d results compared, %0d bad",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/qrpy_pkg.sv
rtl/qrpy_isqrt.sv
rtl/qrpy_cordic.sv
rtl/quaternion_to_roll_pitch_yaw_core.sv
bench/tb_quaternion_to_roll_pitch_yaw_core.sv
